>>> hdl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types and constants of the barometric compensation sequencer.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int CAL_W   = 16;
    localparam int RAW_W   = 24;
    localparam int DT_W    = 26;
    localparam int PROD_W  = 43;
    localparam int OFF_W   = 37;
    localparam int SENS_W  = 35;
    localparam int RPROD_W = 60;
    localparam int DIFF_W  = 40;
    localparam int TEMP_W  = 24;
    localparam int PRESS_W = 27;
    localparam int POS_W   = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [2:0] REG_C1        = 3'd0;
    localparam logic [2:0] REG_C2        = 3'd1;
    localparam logic [2:0] REG_C3        = 3'd2;
    localparam logic [2:0] REG_C4        = 3'd3;
    localparam logic [2:0] REG_C5        = 3'd4;
    localparam logic [2:0] REG_C6        = 3'd5;
    localparam logic [2:0] REG_CONV_TICK = 3'd6;
    localparam logic [2:0] REG_READS     = 3'd7;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_TEMP  = 2'd1;
    localparam logic [1:0] CMD_PRESS = 2'd2;

    localparam logic [1:0] KIND_REJECT = 2'd0;
    localparam logic [1:0] KIND_TEMP   = 2'd1;
    localparam logic [1:0] KIND_PRESS  = 2'd2;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c6;
    } calib_t;

    typedef struct packed {
        logic [CAL_W-1:0] c5;
        logic [7:0]       conversion_ticks;
        logic [3:0]       reads_per_cycle;
    } front_cfg_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [1:0]              cmd;
        logic                    zero;
        logic [RAW_W-1:0]        raw;
        logic signed [DT_W-1:0]  dt;
    } qentry_t;

endpackage

>>> hdl/bcs_front.sv
// ----------------------------------------------------------------------------
// bcs_front
// Poll intake: conversion-time gate, read sequence and temperature difference.
// ----------------------------------------------------------------------------
module bcs_front
    import bcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int TICK_BITS   = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  front_cfg_t             fcfg,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TICK_BITS-1:0]   tick_now,
    input  logic [SAMPLE_BITS-1:0] raw_sample,
    output logic                   q_valid,
    input  logic                   q_stall,
    output qentry_t                q_data
);

    logic [POS_W-1:0]       seq_pos_reg, seq_pos_next;
    logic [TICK_BITS-1:0]   last_tick_reg, last_tick_next;
    logic signed [DT_W-1:0] held_dt_reg, held_dt_next;
    logic [TICK_BITS-1:0]   elapsed;
    logic                   take;
    logic                   due;
    logic [RAW_W-1:0]       raw_ext;
    logic signed [DT_W-1:0] dt_new;
    logic [POS_W:0]         pos_inc;

    assign in_stall = q_stall;
    assign q_valid  = in_valid;
    assign take     = in_valid && !q_stall;
    assign elapsed  = tick_now - last_tick_reg;
    assign due      = elapsed >= TICK_BITS'(fcfg.conversion_ticks);
    assign raw_ext  = RAW_W'(raw_sample);
    assign pos_inc  = (POS_W+1)'(seq_pos_reg) + (POS_W+1)'(1);

    always_comb
    begin
        if (raw_ext == '0)
        begin
            dt_new = '0;
        end
        else
        begin
            dt_new = DT_W'(raw_ext) - DT_W'({fcfg.c5, 8'h00});
        end
    end

    always_comb
    begin
        seq_pos_next   = seq_pos_reg;
        last_tick_next = last_tick_reg;
        held_dt_next   = held_dt_reg;
        q_data.kind    = KIND_REJECT;
        q_data.cmd     = CMD_NONE;
        q_data.zero    = 1'b1;
        q_data.raw     = raw_ext;
        q_data.dt      = held_dt_reg;
        if (due)
        begin
            last_tick_next = tick_now;
            if (seq_pos_reg == '0)
            begin
                held_dt_next = dt_new;
                seq_pos_next = POS_W'(1);
                q_data.kind  = KIND_TEMP;
                q_data.cmd   = CMD_PRESS;
                q_data.zero  = (dt_new == '0);
                q_data.dt    = dt_new;
            end
            else
            begin
                q_data.kind = KIND_PRESS;
                q_data.zero = (raw_ext == '0) || (held_dt_reg == '0);
                if (pos_inc >= (POS_W+1)'(fcfg.reads_per_cycle))
                begin
                    seq_pos_next = '0;
                    q_data.cmd   = CMD_TEMP;
                end
                else
                begin
                    seq_pos_next = pos_inc[POS_W-1:0];
                    q_data.cmd   = CMD_PRESS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_pos_reg   <= '0;
            last_tick_reg <= '0;
            held_dt_reg   <= '0;
        end
        else if (take)
        begin
            seq_pos_reg   <= seq_pos_next;
            last_tick_reg <= last_tick_next;
            held_dt_reg   <= held_dt_next;
        end
    end

endmodule

>>> hdl/bcs_queue.sv
// ----------------------------------------------------------------------------
// bcs_queue
// Short FIFO of classified transactions between the front and back parts.
// ----------------------------------------------------------------------------
module bcs_queue
    import bcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_stall,
    input  qentry_t push_data,
    output logic    pop_valid,
    input  logic    pop_stall,
    output qentry_t pop_data
);

    qentry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/bcs_back.sv
// ----------------------------------------------------------------------------
// bcs_back
// Compensation datapath: multiply sequence, saturation and output register.
// ----------------------------------------------------------------------------
module bcs_back
    import bcs_pkg::*;
#(
    parameter int EXTRA_BITS = 5
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  calib_t                    cal,
    input  logic                      q_valid,
    output logic                      q_stall,
    input  qentry_t                   q_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      accepted,
    output logic [1:0]                next_command,
    output logic                      temp_valid,
    output logic signed [TEMP_W-1:0]  temperature,
    output logic                      press_valid,
    output logic signed [PRESS_W-1:0] pressure
);

    localparam int TSUM_W    = PROD_W + 1;
    localparam int TSHIFT    = 23 - EXTRA_BITS;
    localparam int PSHIFT    = 15 - EXTRA_BITS;
    localparam int TEMP_BASE = 2000 << EXTRA_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_DIFF = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]                 state_reg, state_next;
    qentry_t                    item_reg;
    logic signed [PROD_W-1:0]   prod_a_reg;
    logic signed [PROD_W-1:0]   prod_b_reg;
    logic signed [OFF_W-1:0]    off_reg;
    logic signed [SENS_W-1:0]   sens_reg;
    logic signed [RPROD_W-1:0]  rprod_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       accepted_reg;
    logic [1:0]                 cmd_reg;
    logic                       tv_reg;
    logic signed [TEMP_W-1:0]   temp_reg;
    logic                       pv_reg;
    logic signed [PRESS_W-1:0]  press_reg;

    logic                       take;
    logic                       out_free;
    logic                       load_out;
    logic signed [CAL_W:0]      coef_a;
    logic signed [CAL_W:0]      coef_b;
    logic signed [RAW_W:0]      raw_s;
    logic signed [TSUM_W-1:0]   temp_sum;
    logic signed [DIFF_W-1:0]   press_shift;
    logic signed [TEMP_W-1:0]   temp_sat;
    logic signed [PRESS_W-1:0]  press_sat;

    assign q_stall  = (state_reg != ST_IDLE);
    assign take     = q_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == ST_DONE) && out_free;

    assign coef_a = $signed({1'b0, (item_reg.kind == KIND_TEMP) ? cal.c6 : cal.c4});
    assign coef_b = $signed({1'b0, cal.c3});
    assign raw_s  = $signed({1'b0, item_reg.raw});

    assign temp_sum    = TSUM_W'(prod_a_reg >>> TSHIFT) + TSUM_W'(TEMP_BASE);
    assign press_shift = diff_reg >>> PSHIFT;

    always_comb
    begin
        if (&temp_sum[TSUM_W-1:TEMP_W-1] || ~|temp_sum[TSUM_W-1:TEMP_W-1])
        begin
            temp_sat = temp_sum[TEMP_W-1:0];
        end
        else if (temp_sum[TSUM_W-1])
        begin
            temp_sat = {1'b1, {(TEMP_W-1){1'b0}}};
        end
        else
        begin
            temp_sat = {1'b0, {(TEMP_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        if (&press_shift[DIFF_W-1:PRESS_W-1] || ~|press_shift[DIFF_W-1:PRESS_W-1])
        begin
            press_sat = press_shift[PRESS_W-1:0];
        end
        else if (press_shift[DIFF_W-1])
        begin
            press_sat = {1'b1, {(PRESS_W-1){1'b0}}};
        end
        else
        begin
            press_sat = {1'b0, {(PRESS_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_data.kind == KIND_REJECT) ? ST_DONE : ST_MUL1;
                end
            end
            ST_MUL1: state_next = (item_reg.kind == KIND_TEMP) ? ST_DONE : ST_SUM;
            ST_SUM:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= q_data;
        end
        if (state_reg == ST_MUL1)
        begin
            prod_a_reg <= PROD_W'(item_reg.dt * coef_a);
            prod_b_reg <= PROD_W'(item_reg.dt * coef_b);
        end
        if (state_reg == ST_SUM)
        begin
            off_reg  <= OFF_W'($signed({1'b0, cal.c2, 16'h0000}))
                        + OFF_W'(prod_a_reg >>> 7);
            sens_reg <= SENS_W'($signed({1'b0, cal.c1, 15'h0000}))
                        + SENS_W'(prod_b_reg >>> 8);
        end
        if (state_reg == ST_MUL2)
        begin
            rprod_reg <= RPROD_W'(raw_s * sens_reg);
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= DIFF_W'(rprod_reg >>> 21) - DIFF_W'(off_reg);
        end
        if (load_out)
        begin
            accepted_reg <= (item_reg.kind != KIND_REJECT);
            cmd_reg      <= item_reg.cmd;
            tv_reg       <= (item_reg.kind == KIND_TEMP);
            pv_reg       <= (item_reg.kind == KIND_PRESS);
            temp_reg     <= (item_reg.kind == KIND_TEMP && !item_reg.zero) ? temp_sat : '0;
            press_reg    <= (item_reg.kind == KIND_PRESS && !item_reg.zero) ? press_sat : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign next_command = cmd_reg;
    assign temp_valid   = tv_reg;
    assign temperature  = temp_reg;
    assign press_valid  = pv_reg;
    assign pressure     = press_reg;

endmodule

>>> hdl/baro_compensation_sequencer.sv
// ----------------------------------------------------------------------------
// baro_compensation_sequencer
// Conversion-time gated poll sequencer with first-order pressure compensation.
// ----------------------------------------------------------------------------
// Path: front (combinational), queue, back-end states idle and done for a
// rejected poll, plus MUL1 for a temperature read, plus MUL1, SUM, MUL2, DIFF
// for a pressure read. Flow: the back end takes a new poll only when idle; the
// queue holds up to two polls meanwhile and accepts while a result waits.
// Reset: asynchronous; registers take their defaults (conversion_ticks 10,
// reads_per_cycle 7, rest 0), sequence restarts at a temperature read.
// ----------------------------------------------------------------------------
module baro_compensation_sequencer
    import bcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int TICK_BITS   = 32,
    parameter int EXTRA_BITS  = 5
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_addr,
    input  logic [CAL_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [TICK_BITS-1:0]      tick_now,
    input  logic [SAMPLE_BITS-1:0]    raw_sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      accepted,
    output logic [1:0]                next_command,
    output logic                      temp_valid,
    output logic signed [TEMP_W-1:0]  temperature,
    output logic                      press_valid,
    output logic signed [PRESS_W-1:0] pressure
);

    calib_t     cal_reg;
    front_cfg_t fcfg_reg;
    logic       fq_valid;
    logic       fq_stall;
    qentry_t    fq_data;
    logic       qb_valid;
    logic       qb_stall;
    qentry_t    qb_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg                   <= '0;
            fcfg_reg.c5               <= '0;
            fcfg_reg.conversion_ticks <= 8'd10;
            fcfg_reg.reads_per_cycle  <= 4'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_C1:        cal_reg.c1                <= cfg_wdata;
                REG_C2:        cal_reg.c2                <= cfg_wdata;
                REG_C3:        cal_reg.c3                <= cfg_wdata;
                REG_C4:        cal_reg.c4                <= cfg_wdata;
                REG_C5:        fcfg_reg.c5               <= cfg_wdata;
                REG_C6:        cal_reg.c6                <= cfg_wdata;
                REG_CONV_TICK: fcfg_reg.conversion_ticks <= cfg_wdata[7:0];
                REG_READS:     fcfg_reg.reads_per_cycle  <= cfg_wdata[3:0];
                default:       cal_reg                   <= cal_reg;
            endcase
        end
    end

    bcs_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TICK_BITS   (TICK_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fcfg       (fcfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .tick_now   (tick_now),
        .raw_sample (raw_sample),
        .q_valid    (fq_valid),
        .q_stall    (fq_stall),
        .q_data     (fq_data)
    );

    bcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_stall (fq_stall),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_stall  (qb_stall),
        .pop_data   (qb_data)
    );

    bcs_back #(
        .EXTRA_BITS (EXTRA_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cal          (cal_reg),
        .q_valid      (qb_valid),
        .q_stall      (qb_stall),
        .q_data       (qb_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .next_command (next_command),
        .temp_valid   (temp_valid),
        .temperature  (temperature),
        .press_valid  (press_valid),
        .pressure     (pressure)
    );

endmodule

>>> hdl/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_port_checker
// Port-level checks on result transactions of the sequencer.
// ----------------------------------------------------------------------------
module bcs_port_checker
    import bcs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      accepted,
    input logic [1:0]                next_command,
    input logic                      temp_valid,
    input logic signed [TEMP_W-1:0]  temperature,
    input logic                      press_valid,
    input logic signed [PRESS_W-1:0] pressure
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> next_command == CMD_NONE && !temp_valid
            && !press_valid && temperature == '0 && pressure == '0)
        else $error("rejected poll carries data");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> temp_valid != press_valid)
        else $error("accepted poll must be exactly one read kind");

    a_temp_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && temp_valid |-> next_command == CMD_PRESS && pressure == '0)
        else $error("temperature read must start a pressure conversion");

    a_press_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_valid |-> (next_command == CMD_PRESS
            || next_command == CMD_TEMP) && temperature == '0)
        else $error("pressure read with bad command");

endmodule

bind baro_compensation_sequencer bcs_port_checker u_bcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .next_command (next_command),
    .temp_valid   (temp_valid),
    .temperature  (temperature),
    .press_valid  (press_valid),
    .pressure     (pressure)
);

>>> sim/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_checker
// Watches the poll and result channels and the register write port of the
// barometric compensation sequencer. Each accepted poll transaction is run
// through a local model of the gating, sequencing and fixed-point
// compensation; each result transaction is compared field by field with the
// oldest prediction. The mismatch count and the number of predictions still
// waiting are handed to the testbench top.
// ----------------------------------------------------------------------------
module bcs_checker
    import bcs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_addr,
    input  logic [CAL_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [31:0]               tick_now,
    input  logic [RAW_W-1:0]          raw_sample,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      accepted,
    input  logic [1:0]                next_command,
    input  logic                      temp_valid,
    input  logic signed [TEMP_W-1:0]  temperature,
    input  logic                      press_valid,
    input  logic signed [PRESS_W-1:0] pressure,
    output int                        results_due,
    output int                        mismatches
);

    localparam int     FRAC_BITS = 5;
    localparam int     T_SHIFT   = 23 - FRAC_BITS;
    localparam int     P_SHIFT   = 15 - FRAC_BITS;
    localparam longint T_BASE    = longint'(2000) <<< FRAC_BITS;
    localparam longint TEMP_HI   = (longint'(1) <<< (TEMP_W - 1)) - 1;
    localparam longint TEMP_LO   = -(longint'(1) <<< (TEMP_W - 1));
    localparam longint PRESS_HI  = (longint'(1) <<< (PRESS_W - 1)) - 1;
    localparam longint PRESS_LO  = -(longint'(1) <<< (PRESS_W - 1));

    typedef struct packed {
        logic                      acc;
        logic [1:0]                cmd;
        logic                      tv;
        logic signed [TEMP_W-1:0]  temp;
        logic                      pv;
        logic signed [PRESS_W-1:0] press;
    } poll_result_t;

    logic [CAL_W-1:0] press_sens;
    logic [CAL_W-1:0] press_off;
    logic [CAL_W-1:0] sens_tc;
    logic [CAL_W-1:0] off_tc;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_sens;
    logic [7:0]       conv_ticks;
    logic [3:0]       reads;

    logic [POS_W-1:0] seq_pos;
    logic [31:0]      last_tick;
    longint           delta_temp;

    poll_result_t expected_results[$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // gating, sequence step and compensation of one poll; updates model state
    function automatic poll_result_t compensate_poll(logic [31:0] t, logic [RAW_W-1:0] r);
        poll_result_t res;
        logic [31:0]  elapsed;
        longint       raw;
        longint       val;
        longint       off;
        longint       sens;
        res = '0;
        raw = longint'(r);
        elapsed = t - last_tick;
        if (elapsed >= 32'(conv_ticks)) begin
            res.acc = 1'b1;
            last_tick = t;
            if (seq_pos == '0) begin
                delta_temp = (raw == 0) ? 0 : raw - (longint'(ref_temp) <<< 8);
                if (delta_temp != 0) begin
                    val = T_BASE + ((delta_temp * longint'(temp_sens)) >>> T_SHIFT);
                    val = clamp(val, TEMP_LO, TEMP_HI);
                    res.temp = val[TEMP_W-1:0];
                end
                res.tv = 1'b1;
                res.cmd = CMD_PRESS;
                seq_pos = POS_W'(1);
            end
            else begin
                if (raw != 0 && delta_temp != 0) begin
                    off  = (longint'(press_off) <<< 16)
                         + ((longint'(off_tc) * delta_temp) >>> 7);
                    sens = (longint'(press_sens) <<< 15)
                         + ((longint'(sens_tc) * delta_temp) >>> 8);
                    val  = (((raw * sens) >>> 21) - off) >>> P_SHIFT;
                    val  = clamp(val, PRESS_LO, PRESS_HI);
                    res.press = val[PRESS_W-1:0];
                end
                res.pv = 1'b1;
                if (5'(seq_pos) + 5'd1 >= 5'(reads)) begin
                    seq_pos = '0;
                    res.cmd = CMD_TEMP;
                end
                else begin
                    seq_pos = seq_pos + POS_W'(1);
                    res.cmd = CMD_PRESS;
                end
            end
        end
        else begin
            res.cmd = CMD_NONE;
        end
        return res;
    endfunction

    task automatic report_field(string name, longint want, longint got);
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge clk) begin : monitor
        poll_result_t want;
        if (!rst_n) begin
            press_sens = '0;
            press_off  = '0;
            sens_tc    = '0;
            off_tc     = '0;
            ref_temp   = '0;
            temp_sens  = '0;
            conv_ticks = 8'd10;
            reads      = 4'd7;
            seq_pos    = '0;
            last_tick  = '0;
            delta_temp = 0;
            expected_results.delete();
            results_due = 0;
            mismatches  = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_C1:        press_sens = cfg_wdata;
                    REG_C2:        press_off  = cfg_wdata;
                    REG_C3:        sens_tc    = cfg_wdata;
                    REG_C4:        off_tc     = cfg_wdata;
                    REG_C5:        ref_temp   = cfg_wdata;
                    REG_C6:        temp_sens  = cfg_wdata;
                    REG_CONV_TICK: conv_ticks = cfg_wdata[7:0];
                    REG_READS:     reads      = cfg_wdata[3:0];
                    default:       ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with no prediction waiting", $time);
                    mismatches++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (accepted !== want.acc)
                        report_field("accepted", want.acc, accepted);
                    if (next_command !== want.cmd)
                        report_field("next_command", want.cmd, next_command);
                    if (temp_valid !== want.tv)
                        report_field("temp_valid", want.tv, temp_valid);
                    if (temperature !== want.temp)
                        report_field("temperature", want.temp, temperature);
                    if (press_valid !== want.pv)
                        report_field("press_valid", want.pv, press_valid);
                    if (pressure !== want.press)
                        report_field("pressure", want.press, pressure);
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(compensate_poll(tick_now, raw_sample));
            results_due = expected_results.size();
        end
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the barometric compensation sequencer: a directed pass over
// rejected polls, raw extremes, zero temperature difference and tick wrap,
// then phases of random polls under changing calibration (extremes too),
// conversion time and cycle length, with sender gaps and receiver stalls.
// Checking is done by bcs_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import bcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_POLLS    = 80;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [2:0]                cfg_addr;
    logic [CAL_W-1:0]          cfg_wdata;
    logic                      in_valid;
    logic                      in_stall;
    logic [31:0]               tick_now;
    logic [RAW_W-1:0]          raw_sample;
    logic                      out_valid;
    logic                      out_stall;
    logic                      accepted;
    logic [1:0]                next_command;
    logic                      temp_valid;
    logic signed [TEMP_W-1:0]  temperature;
    logic                      press_valid;
    logic signed [PRESS_W-1:0] pressure;

    int results_due;
    int mismatches;
    int idle_pct;
    int stall_pct;
    int idle_cycles;

    baro_compensation_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick_now     (tick_now),
        .raw_sample   (raw_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .next_command (next_command),
        .temp_valid   (temp_valid),
        .temperature  (temperature),
        .press_valid  (press_valid),
        .pressure     (pressure)
    );

    bcs_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick_now     (tick_now),
        .raw_sample   (raw_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .next_command (next_command),
        .temp_valid   (temp_valid),
        .temperature  (temperature),
        .press_valid  (press_valid),
        .pressure     (pressure),
        .results_due  (results_due),
        .mismatches   (mismatches)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(logic [2:0] addr, logic [CAL_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
    endtask

    // one poll transaction; entered and left at a falling edge
    task automatic send_poll(logic [31:0] t, logic [RAW_W-1:0] r);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        tick_now   <= t;
        raw_sample <= r;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial begin : stimulus
        logic [CAL_W-1:0] cal [6];
        logic [31:0]      tick_cursor;
        logic [31:0]      t;
        logic [RAW_W-1:0] r;
        int               conv_setting;
        int               reads_setting;
        int               pick;

        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        tick_now   = '0;
        raw_sample = '0;
        out_stall  = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        idle_cycles = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: cycle of two, typical calibration
        cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        write_reg(REG_C1, cal[0]);
        write_reg(REG_C2, cal[1]);
        write_reg(REG_C3, cal[2]);
        write_reg(REG_C4, cal[3]);
        write_reg(REG_C5, cal[4]);
        write_reg(REG_C6, cal[5]);
        write_reg(REG_CONV_TICK, 16'd10);
        write_reg(REG_READS, 16'd2);
        cfg_we <= 1'b0;
        @(negedge clk);

        send_poll(32'd0, 24'd123);
        send_poll(32'd9, 24'd5);
        send_poll(32'd10, 24'hFFFFFF);
        send_poll(32'd20, 24'hFFFFFF);
        send_poll(32'd30, 24'd0);
        send_poll(32'd40, 24'd777);
        send_poll(32'd50, {cal[4], 8'h00});
        send_poll(32'd60, 24'h800000);
        send_poll(32'd70, 24'd1);
        send_poll(32'd80, 24'd0);
        send_poll(32'd90, 24'h123456);
        send_poll(32'd100, 24'd1);
        send_poll(32'hFFFFFFFA, 24'h7FFFFF);
        send_poll(32'h00000004, 24'h654321);
        send_poll(32'h00000005, 24'hABCDEF);
        tick_cursor = 32'd5;

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            for (int k = 0; k < 6; k++)
                cal[k] = (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'h0000
                       : 16'($urandom_range(0, 65535));
            conv_setting  = (ph == 3) ? 0 : (ph == 4) ? 255 : $urandom_range(1, 40);
            reads_setting = (ph == 2) ? 0 : (ph == 5) ? 1 : (ph == 6) ? 15
                          : (ph == 4) ? 2 : $urandom_range(2, 15);
            write_reg(REG_C1, cal[0]);
            write_reg(REG_C2, cal[1]);
            write_reg(REG_C3, cal[2]);
            write_reg(REG_C4, cal[3]);
            write_reg(REG_C5, cal[4]);
            write_reg(REG_C6, cal[5]);
            write_reg(REG_CONV_TICK, 16'(conv_setting));
            write_reg(REG_READS, 16'(reads_setting));
            cfg_we <= 1'b0;
            @(negedge clk);

            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            if (ph == 4)
                tick_cursor = 32'hFFFFFF00;

            for (int n = 0; n < PHASE_POLLS; n++) begin
                if (ph == 2 && n == PHASE_POLLS / 2)
                    drain();
                pick = $urandom_range(99);
                if (pick < 75)
                    tick_cursor = tick_cursor + 32'(conv_setting + $urandom_range(0, 20));
                else if (pick < 90)
                    tick_cursor = tick_cursor + 32'($urandom_range(0, conv_setting));
                else
                    tick_cursor = $urandom();
                t = tick_cursor;
                pick = $urandom_range(99);
                if (pick < 5)
                    r = 24'd0;
                else if (pick < 10)
                    r = {cal[4], 8'h00};
                else if (pick < 15)
                    r = 24'hFFFFFF;
                else if (pick < 20)
                    r = 24'd1;
                else
                    r = 24'($urandom());
                send_poll(t, r);
            end
        end

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
